// File: sv/rtt_pkg.sv
// Shared types, constants and codes of the request tag tracker.
package rtt_pkg;

    localparam int SLOTS_DEF = 32;

    localparam int OPC_W   = 8;
    localparam int NODE_W  = 64;
    localparam int TAG_W   = 64;
    localparam int LEN_W   = 21;
    localparam int ERR_W   = 32;
    localparam int SLOT_W  = 5;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = TAG_W + OPC_W + NODE_W;

    localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(36);
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
    localparam logic [TAG_W-1:0] TAG_RESET = TAG_W'(1);

    // Transaction opcodes
    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RESP = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_QUEUED  = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_MATCHED = 2'd2,
        STAT_UNKNOWN = 2'd3
    } stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FREE_SCAN,
        ST_TAG_SCAN
    } ctrl_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;          // capture transaction fields, rewind scan
        logic step;          // advance scan index
        logic claim;         // take current slot, emit queued result
        logic release_slot;  // free compared slot, emit matched result
        logic emit_full;
        logic emit_miss;
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic cur_free;  // slot at scan index is free
        logic idx_last;  // scan index at last slot
        logic hit;       // compare stage matched an active slot
        logic cmp_last;  // compare stage holds last slot
    } dp_stat_t;

endpackage

// File: sv/rtt_ram.sv
// Generic simple dual-port RAM with registered read.
module rtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/rtt_ctrl.sv
// Sequencing controller of the request tag tracker.
module rtt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              op,
    output logic              busy,
    output rtt_pkg::dp_cmd_t  cmd,
    input  rtt_pkg::dp_stat_t dp_stat
);

    rtt_pkg::ctrl_state_t state_reg;
    rtt_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (op == rtt_pkg::OP_RESP) ? rtt_pkg::ST_TAG_SCAN
                                                          : rtt_pkg::ST_FREE_SCAN;
                end
            end
            rtt_pkg::ST_FREE_SCAN:
            begin
                if (dp_stat.cur_free || dp_stat.idx_last)
                begin
                    state_next = rtt_pkg::ST_IDLE;
                end
            end
            rtt_pkg::ST_TAG_SCAN:
            begin
                if (dp_stat.hit || dp_stat.cmp_last)
                begin
                    state_next = rtt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rtt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            rtt_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            rtt_pkg::ST_FREE_SCAN:
            begin
                cmd.claim     = dp_stat.cur_free;
                cmd.emit_full = !dp_stat.cur_free && dp_stat.idx_last;
                cmd.step      = !dp_stat.cur_free && !dp_stat.idx_last;
            end
            rtt_pkg::ST_TAG_SCAN:
            begin
                cmd.release_slot = dp_stat.hit;
                cmd.emit_miss    = !dp_stat.hit && dp_stat.cmp_last;
                cmd.step         = !dp_stat.hit && !dp_stat.cmp_last;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// File: sv/rtt_datapath.sv
// Slot table, scan counter, tag compare and result registers.
module rtt_datapath #(
    parameter int SLOTS = rtt_pkg::SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rtt_pkg::dp_cmd_t             cmd,
    output rtt_pkg::dp_stat_t            dp_stat,
    input  logic [rtt_pkg::OPC_W-1:0]    req_opcode,
    input  logic [rtt_pkg::NODE_W-1:0]   node_id,
    input  logic [rtt_pkg::LEN_W-1:0]    arg_len,
    input  logic [rtt_pkg::TAG_W-1:0]    resp_unique,
    input  logic signed [rtt_pkg::ERR_W-1:0] resp_error,
    output logic                         done,
    output logic [rtt_pkg::STAT_W-1:0]   status,
    output logic [rtt_pkg::SLOT_W-1:0]   slot,
    output logic [rtt_pkg::TAG_W-1:0]    tag,
    output logic [rtt_pkg::LEN_W-1:0]    total_len,
    output logic [rtt_pkg::OPC_W-1:0]    match_opcode,
    output logic [rtt_pkg::NODE_W-1:0]   match_node,
    output logic signed [rtt_pkg::ERR_W-1:0] match_error
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    // captured transaction
    logic [rtt_pkg::OPC_W-1:0]        opc_reg;
    logic [rtt_pkg::NODE_W-1:0]       node_reg;
    logic [rtt_pkg::LEN_W-1:0]        alen_reg;
    logic [rtt_pkg::TAG_W-1:0]        runiq_reg;
    logic signed [rtt_pkg::ERR_W-1:0] rerr_reg;

    logic [SLOTS-1:0]           active_reg;
    logic [rtt_pkg::TAG_W-1:0]  next_tag_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           cmp_idx_reg;
    logic                       cmp_valid_reg;

    logic                         done_reg;
    logic [rtt_pkg::STAT_W-1:0]   status_reg;
    logic [rtt_pkg::SLOT_W-1:0]   slot_reg;
    logic [rtt_pkg::TAG_W-1:0]    tag_reg;
    logic [rtt_pkg::LEN_W-1:0]    total_len_reg;
    logic [rtt_pkg::OPC_W-1:0]    mopc_reg;
    logic [rtt_pkg::NODE_W-1:0]   mnode_reg;
    logic signed [rtt_pkg::ERR_W-1:0] merr_reg;

    logic [rtt_pkg::ENTRY_W-1:0]  wr_entry;
    logic [rtt_pkg::ENTRY_W-1:0]  rd_entry;
    logic [rtt_pkg::TAG_W-1:0]    rd_tag;
    logic [rtt_pkg::OPC_W-1:0]    rd_opc;
    logic [rtt_pkg::NODE_W-1:0]   rd_node;
    logic [rtt_pkg::LEN_W:0]      len_sum;
    logic [rtt_pkg::LEN_W-1:0]    len_sat;
    logic [IDX_W+rtt_pkg::SLOT_W-1:0] idx_ext;
    logic [IDX_W+rtt_pkg::SLOT_W-1:0] cmp_ext;

    assign wr_entry = {next_tag_reg, opc_reg, node_reg};
    assign rd_tag   = rd_entry[rtt_pkg::ENTRY_W-1 -: rtt_pkg::TAG_W];
    assign rd_opc   = rd_entry[rtt_pkg::NODE_W +: rtt_pkg::OPC_W];
    assign rd_node  = rd_entry[rtt_pkg::NODE_W-1:0];

    rtt_ram #(
        .WIDTH (rtt_pkg::ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (cmd.claim),
        .waddr (idx_reg),
        .wdata (wr_entry),
        .raddr (idx_reg),
        .rdata (rd_entry)
    );

    assign len_sum = {1'b0, rtt_pkg::HDR_LEN} + {1'b0, alen_reg};
    assign len_sat = len_sum[rtt_pkg::LEN_W] ? rtt_pkg::LEN_MAX
                                             : len_sum[rtt_pkg::LEN_W-1:0];

    assign idx_ext = {{rtt_pkg::SLOT_W{1'b0}}, idx_reg};
    assign cmp_ext = {{rtt_pkg::SLOT_W{1'b0}}, cmp_idx_reg};

    assign dp_stat.cur_free = !active_reg[idx_reg];
    assign dp_stat.idx_last = (idx_reg == IDX_LAST);
    assign dp_stat.hit      = cmp_valid_reg && active_reg[cmp_idx_reg]
                              && (rd_tag == runiq_reg);
    assign dp_stat.cmp_last = cmp_valid_reg && (cmp_idx_reg == IDX_LAST);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            opc_reg   <= req_opcode;
            node_reg  <= node_id;
            alen_reg  <= arg_len;
            runiq_reg <= resp_unique;
            rerr_reg  <= resp_error;
        end
    end

    // control state: occupancy, tag counter, scan position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            next_tag_reg  <= rtt_pkg::TAG_RESET;
            idx_reg       <= '0;
            cmp_idx_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.claim || cmd.release_slot || cmd.emit_full || cmd.emit_miss;
            if (cmd.load)
            begin
                idx_reg       <= '0;
                cmp_valid_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                if (idx_reg != IDX_LAST)
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                cmp_idx_reg   <= idx_reg;
                cmp_valid_reg <= 1'b1;
            end
            if (cmd.claim)
            begin
                active_reg[idx_reg] <= 1'b1;
                next_tag_reg        <= next_tag_reg + rtt_pkg::TAG_W'(1);
            end
            if (cmd.release_slot)
            begin
                active_reg[cmp_idx_reg] <= 1'b0;
            end
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.claim || cmd.release_slot || cmd.emit_full || cmd.emit_miss)
        begin
            status_reg    <= rtt_pkg::STAT_FULL;
            slot_reg      <= '0;
            tag_reg       <= '0;
            total_len_reg <= '0;
            mopc_reg      <= '0;
            mnode_reg     <= '0;
            merr_reg      <= '0;
            if (cmd.claim)
            begin
                status_reg    <= rtt_pkg::STAT_QUEUED;
                slot_reg      <= idx_ext[rtt_pkg::SLOT_W-1:0];
                tag_reg       <= next_tag_reg;
                total_len_reg <= len_sat;
            end
            else if (cmd.release_slot)
            begin
                status_reg <= rtt_pkg::STAT_MATCHED;
                slot_reg   <= cmp_ext[rtt_pkg::SLOT_W-1:0];
                tag_reg    <= rd_tag;
                mopc_reg   <= rd_opc;
                mnode_reg  <= rd_node;
                merr_reg   <= rerr_reg;
            end
            else if (cmd.emit_miss)
            begin
                status_reg <= rtt_pkg::STAT_UNKNOWN;
                tag_reg    <= runiq_reg;
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign slot         = slot_reg;
    assign tag          = tag_reg;
    assign total_len    = total_len_reg;
    assign match_opcode = mopc_reg;
    assign match_node   = mnode_reg;
    assign match_error  = merr_reg;

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.claim, cmd.release_slot, cmd.emit_full, cmd.emit_miss}))
        else $error("more than one result command in a cycle");

    a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.claim |=> active_reg[$past(idx_reg)])
        else $error("claimed slot not marked active");

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.release_slot |=> !active_reg[$past(cmp_idx_reg)])
        else $error("released slot still active");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    a_tag_advance: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_full |=> (next_tag_reg == $past(next_tag_reg)))
        else $error("tag counter moved on a full table");

endmodule

// File: sv/request_tag_tracker.sv
// Top level of the request tag tracker: controller plus slot table datapath.
//
//  Channel  Handshake           Fields
//  -------  ------------------  --------------------------------------------------------
//  command  start in, busy out  op req_opcode node_id arg_len resp_unique resp_error
//  result   done out, 1 cycle   status slot tag total_len match_opcode match_node match_error
//
// A transaction is taken on an edge with start high and busy low; busy stays high until
// the result is registered. Send: the scan ends at the lowest free slot, or at the last
// slot when the table is full. Response: the tag compare works on the registered entry
// RAM read and ends at the lowest matching slot, or at the last slot on a miss.
// done is high for the first cycle with busy low and cannot be stalled; a new transaction
// may be taken in that cycle. Reset clears occupancy and sets the tag counter to one.
module request_tag_tracker #(
    parameter int SLOTS = rtt_pkg::SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             op,
    input  logic [rtt_pkg::OPC_W-1:0]        req_opcode,
    input  logic [rtt_pkg::NODE_W-1:0]       node_id,
    input  logic [rtt_pkg::LEN_W-1:0]        arg_len,
    input  logic [rtt_pkg::TAG_W-1:0]        resp_unique,
    input  logic signed [rtt_pkg::ERR_W-1:0] resp_error,
    output logic                             done,
    output logic [rtt_pkg::STAT_W-1:0]       status,
    output logic [rtt_pkg::SLOT_W-1:0]       slot,
    output logic [rtt_pkg::TAG_W-1:0]        tag,
    output logic [rtt_pkg::LEN_W-1:0]        total_len,
    output logic [rtt_pkg::OPC_W-1:0]        match_opcode,
    output logic [rtt_pkg::NODE_W-1:0]       match_node,
    output logic signed [rtt_pkg::ERR_W-1:0] match_error
);

    rtt_pkg::dp_cmd_t  cmd;
    rtt_pkg::dp_stat_t dp_stat;

    // Controller: idle / free-slot scan / tag scan
    rtt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .op      (op),
        .busy    (busy),
        .cmd     (cmd),
        .dp_stat (dp_stat)
    );

    // Datapath: occupancy bits, entry RAM, tag counter, result registers
    rtt_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .dp_stat      (dp_stat),
        .req_opcode   (req_opcode),
        .node_id      (node_id),
        .arg_len      (arg_len),
        .resp_unique  (resp_unique),
        .resp_error   (resp_error),
        .done         (done),
        .status       (status),
        .slot         (slot),
        .tag          (tag),
        .total_len    (total_len),
        .match_opcode (match_opcode),
        .match_node   (match_node),
        .match_error  (match_error)
    );

endmodule

// File: tb/request_tag_tracker_checker.sv
// Scoreboard for the request tag tracker: shadow slot table, expected replies, compare.
module request_tag_tracker_checker #(
    parameter int SLOTS = rtt_pkg::SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic                             op,
    input  logic [rtt_pkg::OPC_W-1:0]        req_opcode,
    input  logic [rtt_pkg::NODE_W-1:0]       node_id,
    input  logic [rtt_pkg::LEN_W-1:0]        arg_len,
    input  logic [rtt_pkg::TAG_W-1:0]        resp_unique,
    input  logic signed [rtt_pkg::ERR_W-1:0] resp_error,
    input  logic                             done,
    input  logic [rtt_pkg::STAT_W-1:0]       status,
    input  logic [rtt_pkg::SLOT_W-1:0]       slot,
    input  logic [rtt_pkg::TAG_W-1:0]        tag,
    input  logic [rtt_pkg::LEN_W-1:0]        total_len,
    input  logic [rtt_pkg::OPC_W-1:0]        match_opcode,
    input  logic [rtt_pkg::NODE_W-1:0]       match_node,
    input  logic signed [rtt_pkg::ERR_W-1:0] match_error,
    output int                               mismatch_count,
    output int                               open_count
);

    typedef struct packed {
        rtt_pkg::stat_t                   status;
        logic [rtt_pkg::SLOT_W-1:0]       slot;
        logic [rtt_pkg::TAG_W-1:0]        tag;
        logic [rtt_pkg::LEN_W-1:0]        total_len;
        logic [rtt_pkg::OPC_W-1:0]        opcode;
        logic [rtt_pkg::NODE_W-1:0]       node;
        logic signed [rtt_pkg::ERR_W-1:0] err;
    } reply_t;

    // shadow table
    bit                         live[SLOTS];
    logic [rtt_pkg::TAG_W-1:0]  stored_tag[SLOTS];
    logic [rtt_pkg::OPC_W-1:0]  stored_opcode[SLOTS];
    logic [rtt_pkg::NODE_W-1:0] stored_node[SLOTS];
    logic [rtt_pkg::TAG_W-1:0]  next_tag;

    reply_t pending_replies[$];
    reply_t want;

    // Applies one transaction to the shadow table and returns the reply it must produce.
    function automatic reply_t table_reply(input logic cmd_op,
                                           input logic [rtt_pkg::OPC_W-1:0] opc,
                                           input logic [rtt_pkg::NODE_W-1:0] node,
                                           input logic [rtt_pkg::LEN_W-1:0] alen,
                                           input logic [rtt_pkg::TAG_W-1:0] runiq,
                                           input logic signed [rtt_pkg::ERR_W-1:0] rerr);
        reply_t                    r;
        logic [rtt_pkg::LEN_W:0]   len_sum;
        bit                        found;
        int                        i;
        r = '0;
        found = 1'b0;
        if (cmd_op == rtt_pkg::OP_SEND)
        begin
            r.status = rtt_pkg::STAT_FULL;
            for (i = 0; i < SLOTS; i++)
            begin
                if (!found && !live[i])
                begin
                    found = 1'b1;
                    len_sum = {1'b0, alen} + {1'b0, rtt_pkg::HDR_LEN};
                    live[i] = 1'b1;
                    stored_tag[i] = next_tag;
                    stored_opcode[i] = opc;
                    stored_node[i] = node;
                    r.status = rtt_pkg::STAT_QUEUED;
                    r.slot = rtt_pkg::SLOT_W'(i);
                    r.tag = next_tag;
                    r.total_len = len_sum[rtt_pkg::LEN_W] ? rtt_pkg::LEN_MAX
                                                          : len_sum[rtt_pkg::LEN_W-1:0];
                    next_tag = next_tag + rtt_pkg::TAG_W'(1);
                end
            end
        end
        else
        begin
            r.status = rtt_pkg::STAT_UNKNOWN;
            r.tag = runiq;
            for (i = 0; i < SLOTS; i++)
            begin
                if (!found && live[i] && stored_tag[i] == runiq)
                begin
                    found = 1'b1;
                    live[i] = 1'b0;
                    r.status = rtt_pkg::STAT_MATCHED;
                    r.slot = rtt_pkg::SLOT_W'(i);
                    r.tag = stored_tag[i];
                    r.opcode = stored_opcode[i];
                    r.node = stored_node[i];
                    r.err = rerr;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int i;
        if (!rst_n)
        begin
            for (i = 0; i < SLOTS; i++)
            begin
                live[i] = 1'b0;
                stored_tag[i] = '0;
                stored_opcode[i] = '0;
                stored_node[i] = '0;
            end
            next_tag = rtt_pkg::TAG_RESET;
            pending_replies.delete();
            open_count = 0;
            mismatch_count = 0;
        end
        else
        begin
            // reply of the previous transaction may share this edge with a new one
            if (done)
            begin
                if (pending_replies.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected reply: status=%0d slot=%0d tag=%h",
                                 status, slot, tag);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (status !== want.status || slot !== want.slot || tag !== want.tag ||
                        total_len !== want.total_len || match_opcode !== want.opcode ||
                        match_node !== want.node || match_error !== want.err)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("reply mismatch at %0t", $realtime);
                            $display("  exp: st=%0d slot=%0d tag=%h len=%0d opc=%h node=%h err=%0d",
                                     want.status, want.slot, want.tag, want.total_len,
                                     want.opcode, want.node, want.err);
                            $display("  got: st=%0d slot=%0d tag=%h len=%0d opc=%h node=%h err=%0d",
                                     status, slot, tag, total_len, match_opcode, match_node,
                                     match_error);
                        end
                    end
                end
            end
            if (start && !busy)
                pending_replies.push_back(table_reply(op, req_opcode, node_id, arg_len,
                                                      resp_unique, resp_error));
            open_count = pending_replies.size();
        end
    end

endmodule

// File: tb/request_tag_tracker_test.sv
// Stimulus and verdict for the request tag tracker, checked by request_tag_tracker_checker.
module request_tag_tracker_test;

    localparam int SLOTS      = rtt_pkg::SLOTS_DEF;
    localparam int RAND_ITEMS = 1500;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic                             op = rtt_pkg::OP_SEND;
    logic [rtt_pkg::OPC_W-1:0]        req_opcode = '0;
    logic [rtt_pkg::NODE_W-1:0]       node_id = '0;
    logic [rtt_pkg::LEN_W-1:0]        arg_len = '0;
    logic [rtt_pkg::TAG_W-1:0]        resp_unique = '0;
    logic signed [rtt_pkg::ERR_W-1:0] resp_error = '0;
    logic                             done;
    logic [rtt_pkg::STAT_W-1:0]       status;
    logic [rtt_pkg::SLOT_W-1:0]       slot;
    logic [rtt_pkg::TAG_W-1:0]        tag;
    logic [rtt_pkg::LEN_W-1:0]        total_len;
    logic [rtt_pkg::OPC_W-1:0]        match_opcode;
    logic [rtt_pkg::NODE_W-1:0]       match_node;
    logic signed [rtt_pkg::ERR_W-1:0] match_error;

    int mismatch_count;
    int open_count;

    // Tags the block has handed out and not yet taken back; lets most responses hit.
    logic [rtt_pkg::TAG_W-1:0] live_tags[$];
    logic [rtt_pkg::TAG_W-1:0] last_tag = rtt_pkg::TAG_RESET;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    request_tag_tracker #(
        .SLOTS(SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .req_opcode(req_opcode),
        .node_id(node_id),
        .arg_len(arg_len),
        .resp_unique(resp_unique),
        .resp_error(resp_error),
        .done(done),
        .status(status),
        .slot(slot),
        .tag(tag),
        .total_len(total_len),
        .match_opcode(match_opcode),
        .match_node(match_node),
        .match_error(match_error)
    );

    request_tag_tracker_checker #(
        .SLOTS(SLOTS)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .req_opcode(req_opcode),
        .node_id(node_id),
        .arg_len(arg_len),
        .resp_unique(resp_unique),
        .resp_error(resp_error),
        .done(done),
        .status(status),
        .slot(slot),
        .tag(tag),
        .total_len(total_len),
        .match_opcode(match_opcode),
        .match_node(match_node),
        .match_error(match_error),
        .mismatch_count(mismatch_count),
        .open_count(open_count)
    );

    // Track issued/freed tags from the result strobe. Only steers stimulus; a
    // response picked from here may already be gone, which just makes it a miss.
    always @(posedge clk)
    begin : harvest
        int k;
        int hit_at;
        if (done)
        begin
            if (status == rtt_pkg::STAT_QUEUED)
            begin
                live_tags.push_back(tag);
                last_tag = tag;
            end
            else if (status == rtt_pkg::STAT_MATCHED)
            begin
                hit_at = -1;
                for (k = 0; k < live_tags.size(); k++)
                    if (hit_at < 0 && live_tags[k] == tag)
                        hit_at = k;
                if (hit_at >= 0)
                    live_tags.delete(hit_at);
            end
        end
    end

    // Present one transaction and hold it until the block takes it (start high, busy low
    // at the edge). start stays high on return so back-to-back transactions need no toggle.
    task automatic issue(input logic cmd_op, input logic [rtt_pkg::OPC_W-1:0] opc,
                         input logic [rtt_pkg::NODE_W-1:0] node,
                         input logic [rtt_pkg::LEN_W-1:0] alen,
                         input logic [rtt_pkg::TAG_W-1:0] runiq,
                         input logic [rtt_pkg::ERR_W-1:0] rerr);
        start <= 1'b1;
        op <= cmd_op;
        req_opcode <= opc;
        node_id <= node;
        arg_len <= alen;
        resp_unique <= runiq;
        resp_error <= rerr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Response-only fields on a send and send-only fields on a response get noise.
    task automatic send_request(input logic [rtt_pkg::OPC_W-1:0] opc,
                                input logic [rtt_pkg::NODE_W-1:0] node,
                                input logic [rtt_pkg::LEN_W-1:0] alen);
        issue(rtt_pkg::OP_SEND, opc, node, alen, {$urandom, $urandom}, $urandom);
    endtask

    task automatic deliver_response(input logic [rtt_pkg::TAG_W-1:0] runiq,
                                    input logic [rtt_pkg::ERR_W-1:0] rerr);
        issue(rtt_pkg::OP_RESP, rtt_pkg::OPC_W'($urandom_range(0, 255)), {$urandom, $urandom},
              rtt_pkg::LEN_W'($urandom_range(0, (1 << rtt_pkg::LEN_W) - 1)), runiq, rerr);
    endtask

    // Sender gap: start goes low and waits a clock for as long as a 13-in-100 draw keeps hitting.
    task automatic sender_gap();
        while ($urandom_range(0, 99) < 13)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stop sending until every expected reply has shown up.
    task automatic wait_for_replies();
        start <= 1'b0;
        @(posedge clk);
        while (open_count != 0)
            @(posedge clk);
    endtask

    // Mostly small argument lengths, some anywhere in the 21-bit field, some right at the
    // edge where header plus arguments no longer fit.
    function automatic logic [rtt_pkg::LEN_W-1:0] pick_len();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return rtt_pkg::LEN_W'($urandom_range(0, 4096));
            6, 7:             return rtt_pkg::LEN_W'($urandom_range(0, 1048576));
            8:                return rtt_pkg::LEN_W'($urandom);
            default:          return rtt_pkg::LEN_MAX - rtt_pkg::LEN_W'($urandom_range(0, 72));
        endcase
    endfunction

    // Mostly a tag that is still outstanding; otherwise a likely miss.
    function automatic logic [rtt_pkg::TAG_W-1:0] pick_tag();
        if (live_tags.size() != 0 && $urandom_range(0, 99) < 80)
            return live_tags[$urandom_range(0, live_tags.size() - 1)];
        case ($urandom_range(0, 3))
            0:       return {$urandom, $urandom};
            1:       return '0;
            2:       return '1;
            default: return last_tag + rtt_pkg::TAG_W'($urandom_range(0, 3));
        endcase
    endfunction

    initial
    begin : stimulus
        int  n;
        int  send_pct;
        bit  quiet;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, saturation edge, hit/miss, slot reuse.
        send_request(8'h00, '0, '0);                         // tag 1, slot 0, len 36
        send_request(8'hff, '1, rtt_pkg::LEN_MAX);           // saturates
        send_request(8'h5a, 64'h8000_0000_0000_0000, rtt_pkg::LEN_MAX - 21'd36); // exactly fits
        send_request(8'ha5, 64'h0123_4567_89ab_cdef, rtt_pkg::LEN_MAX - 21'd35); // one over
        send_request(8'h3c, 64'hfedc_ba98_7654_3210, 21'd1048576);
        deliver_response(64'd2, 32'h8000_0000);              // hit slot 1, most negative error
        deliver_response(64'd2, 32'd5);                      // already freed: unknown
        deliver_response('0, 32'hffff_ffff);                 // tag zero never issued yet
        deliver_response('1, 32'h7fff_ffff);
        send_request(8'h81, 64'h1, 21'd1);                   // reuses lowest free slot (1)
        deliver_response(64'd1, 32'h7fff_ffff);              // hit slot 0, most positive error
        deliver_response(64'd6, 32'hffff_ffff);
        deliver_response(64'd5, 32'd0);                      // matches a higher slot
        deliver_response(64'd3, 32'h1234_5678);
        deliver_response(64'd4, 32'hedcb_a987);

        // Let the table settle before the random part.
        wait_for_replies();

        // Random part in phases of 100: filling (runs into table full), mixed, draining
        // (runs into misses on an empty table). No sender gaps in the middle stretch.
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            case ((n / 100) % 3)
                0:       send_pct = 80;
                1:       send_pct = 50;
                default: send_pct = 25;
            endcase
            quiet = (n >= 600 && n < 900);
            if (n == 750)
                wait_for_replies();
            if (!quiet)
                sender_gap();
            if ($urandom_range(0, 99) < send_pct)
                send_request(rtt_pkg::OPC_W'($urandom_range(0, 255)), {$urandom, $urandom},
                             pick_len());
            else
                deliver_response(pick_tag(), $urandom);
        end

        // Drain, then give the block a full scan worth of cycles for stray strobes.
        wait_for_replies();
        repeat (SLOTS + 8)
            @(posedge clk);

        if (mismatch_count == 0 && open_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: ends the run with a failure if the stimulus hangs.
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
sv/rtt_pkg.sv
sv/rtt_ram.sv
sv/rtt_ctrl.sv
sv/rtt_datapath.sv
sv/request_tag_tracker.sv
tb/request_tag_tracker_checker.sv
tb/request_tag_tracker_test.sv
